[src/rsi_pkg.sv]
// shared types and constants for the ray and sphere intersection core
// no dependencies; every other file uses it, by scoped names or by import
`default_nettype none

package rsi_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;               // coordinate width
    localparam int RAD_W     = 31;               // radius width
    localparam int TOL_W     = 16;               // tolerance width
    localparam int UW        = FRAC_BITS + 2;    // unit direction component, signed
    localparam int QB        = FRAC_BITS + 1;    // quotient bits of the normalizer
    localparam int NW        = CW + FRAC_BITS;   // normalizer numerator width
    localparam int DRW       = NW + 1;           // divider partial remainder width
    localparam int PW        = CW + 3;           // projection length, signed
    localparam int WW        = CW + 4;           // offset from center, signed
    localparam int TW        = CW + 4;           // distance along the ray, signed

    // root unit
    localparam int SQ_W   = 64;
    localparam int SQ_R   = SQ_W / 2;
    localparam int SQ_LAT = SQ_R;
    localparam int DIV_LAT = QB;

    // queues
    localparam int QD = 4;
    localparam int QA = 2;

    // configuration register index
    localparam int IDX_W = 3;
    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_TOLERANCE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic [RAD_W-1:0]     radius;
        logic [TOL_W-1:0]     tolerance;
    } t_cfg;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } t_hit;

    // front sideband while the length is formed
    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
    } t_fside;

    // normalized ray handed from front to back
    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][UW-1:0] u;
        logic [PW-1:0]      proj;
        logic               miss;
    } t_norm;

endpackage

`default_nettype wire

[src/ray_sphere_intersect_core.sv]
// Ray and sphere intersection in signed fixed point (Q16.16). Push one ray per cycle
// (origin, direction of any length); pop one result per ray, in order: hit flag and the
// nearest point where the ray meets the configured sphere no more than the tolerance
// behind its origin, or all zero on a miss. Throughput is one ray per clock while
// neither side stalls. The front forms the squared length, takes the pipelined length
// root, normalizes the direction with a divider per component and forms the projection;
// a queue lies between the parts, the back has its own 32-stage root for the chord, and
// a result queue holds the output. Write the sphere registers only while no ray is in flight.
// Depends on rsi_pkg, rsi_front, rsi_back.
`default_nettype none

module ray_sphere_intersect_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [rsi_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rsi_pkg::CW-1:0]       i_cfg_data,
    input  wire logic                         push,
    output logic                              full,
    input  wire rsi_pkg::t_ray                i_ray,
    output logic                              empty,
    input  wire logic                         pop,
    output rsi_pkg::t_hit                     o_hit
);

    rsi_pkg::t_cfg  r_cfg;
    rsi_pkg::t_norm w_norm;
    logic           w_fvld, w_brdy, w_mid_push;

    // sphere registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x  <= '0;
            r_cfg.center_y  <= '0;
            r_cfg.center_z  <= '0;
            r_cfg.radius    <= rsi_pkg::RAD_W'(1) << rsi_pkg::FRAC_BITS;
            r_cfg.tolerance <= rsi_pkg::TOL_W'(1);
        end else if (i_cfg_we) begin
            case (rsi_pkg::t_reg_idx'(i_cfg_idx))
                rsi_pkg::REG_CENTER_X: begin
                    r_cfg.center_x <= i_cfg_data;
                end
                rsi_pkg::REG_CENTER_Y: begin
                    r_cfg.center_y <= i_cfg_data;
                end
                rsi_pkg::REG_CENTER_Z: begin
                    r_cfg.center_z <= i_cfg_data;
                end
                rsi_pkg::REG_RADIUS: begin
                    r_cfg.radius <= i_cfg_data[rsi_pkg::RAD_W-1:0];
                end
                rsi_pkg::REG_TOLERANCE: begin
                    r_cfg.tolerance <= i_cfg_data[rsi_pkg::TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front to back request transfer
    assign w_mid_push = w_fvld && w_brdy;

    rsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (push),
        .i_ray   (i_ray),
        .o_full  (full),
        .o_vld   (w_fvld),
        .o_norm  (w_norm),
        .i_rdy   (w_brdy)
    );

    rsi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (w_mid_push),
        .i_norm  (w_norm),
        .o_rdy   (w_brdy),
        .o_empty (empty),
        .i_pop   (pop),
        .o_hit   (o_hit)
    );

endmodule

`default_nettype wire

[src/rsi_sqrt.sv]
// pipelined integer square root, one root bit per stage, rounded down
// depends on rsi_pkg
`default_nettype none

module rsi_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [rsi_pkg::SQ_W-1:0]  i_x,
    output logic      [rsi_pkg::SQ_R-1:0]  o_root
);

    localparam int XW = rsi_pkg::SQ_W;
    localparam int RW = rsi_pkg::SQ_R;
    localparam int L  = rsi_pkg::SQ_LAT;

    logic [XW-1:0] r_rem  [L];
    logic [RW-1:0] r_root [L];
    logic [XW-1:0] n_rem  [L];
    logic [RW-1:0] n_root [L];
    logic [XW-1:0] w_rem  [L];
    logic [RW-1:0] w_root [L];
    logic [XW:0]   w_sub  [L];

    // per stage: try the next root bit against the remainder
    always_comb begin
        for (int k = 0; k < L; k++) begin
            if (k == 0) begin
                w_rem[k]  = i_x;
                w_root[k] = '0;
            end else begin
                w_rem[k]  = r_rem[k-1];
                w_root[k] = r_root[k-1];
            end
            w_sub[k] = ((XW+1)'(w_root[k]) << (L - k)) + ((XW+1)'(1) << (2 * (L - 1 - k)));
            if ({1'b0, w_rem[k]} >= w_sub[k]) begin
                n_rem[k]  = w_rem[k] - w_sub[k][XW-1:0];
                n_root[k] = w_root[k] | (RW'(1) << (L - 1 - k));
            end else begin
                n_rem[k]  = w_rem[k];
                n_root[k] = w_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < L; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[L-1];

endmodule

`default_nettype wire

[src/rsi_div.sv]
// pipelined restoring divider for one direction component, one quotient bit per stage
// depends on rsi_pkg
`default_nettype none

module rsi_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [rsi_pkg::NW-1:0]   i_num,
    input  wire logic [rsi_pkg::CW-1:0]   i_den,
    output logic      [rsi_pkg::QB-1:0]   o_quo
);

    localparam int L  = rsi_pkg::DIV_LAT;
    localparam int RW = rsi_pkg::DRW;
    localparam int DW = rsi_pkg::CW;
    localparam int QW = rsi_pkg::QB;

    logic [RW-1:0] r_rem [L];
    logic [DW-1:0] r_den [L];
    logic [QW-1:0] r_quo [L];
    logic [RW-1:0] n_rem [L];
    logic [QW-1:0] n_quo [L];
    logic [RW-1:0] w_rem [L];
    logic [DW-1:0] w_den [L];
    logic [QW-1:0] w_quo [L];
    logic [RW-1:0] w_sub [L];

    // per stage: subtract the shifted divisor where it fits
    always_comb begin
        for (int k = 0; k < L; k++) begin
            if (k == 0) begin
                w_rem[k] = RW'(i_num);
                w_den[k] = i_den;
                w_quo[k] = '0;
            end else begin
                w_rem[k] = r_rem[k-1];
                w_den[k] = r_den[k-1];
                w_quo[k] = r_quo[k-1];
            end
            w_sub[k] = RW'(w_den[k]) << (L - 1 - k);
            if (w_rem[k] >= w_sub[k]) begin
                n_rem[k] = w_rem[k] - w_sub[k];
                n_quo[k] = w_quo[k] | (QW'(1) << (L - 1 - k));
            end else begin
                n_rem[k] = w_rem[k];
                n_quo[k] = w_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < L; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[L-1];

endmodule

`default_nettype wire

[src/rsi_front.sv]
// front part: takes rays, normalizes the direction and projects the center offset
// depends on rsi_pkg, rsi_sqrt, rsi_div
`default_nettype none

module rsi_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rsi_pkg::t_cfg   i_cfg,
    input  wire logic            i_push,
    input  wire rsi_pkg::t_ray   i_ray,
    output logic                 o_full,
    output logic                 o_vld,
    output rsi_pkg::t_norm       o_norm,
    input  wire logic            i_rdy
);

    localparam int F   = rsi_pkg::FRAC_BITS;
    localparam int CW  = rsi_pkg::CW;
    localparam int UW  = rsi_pkg::UW;
    localparam int SL  = rsi_pkg::SQ_LAT;
    localparam int DL  = rsi_pkg::SQ_LAT + rsi_pkg::DIV_LAT;
    localparam int PRW = CW + 1 + UW;

    logic w_en;

    logic r_v1, r_v2, r_v3, r_vp1, r_vp2, r_vp3;
    logic r_vd [DL];

    rsi_pkg::t_fside n_s1, r_s1, r_s2, n_s3, r_s3;
    rsi_pkg::t_fside r_sd [DL];
    rsi_pkg::t_fside r_n1, r_n2;
    rsi_pkg::t_norm  n_out, r_out;

    logic [2:0][CW-1:0]      w_o, w_d, w_c;
    logic [2*CW-1:0]         r_sq [3];
    logic [2*CW-1:0]         n_len2, r_len2;
    logic [CW-1:0]           w_len;
    logic [rsi_pkg::QB-1:0]  w_q [3];
    logic [2:0][UW-1:0]      n_u, r_u, r_u2;
    logic signed [CW:0]      w_co [3];
    logic signed [PRW-1:0]   r_pr [3];
    logic signed [PRW-1:0]   w_psum;

    // the whole front moves together unless its last item is blocked
    assign w_en   = !r_vp3 || i_rdy;
    assign o_full = !w_en;
    assign o_vld  = r_vp3;
    assign o_norm = r_out;

    assign w_o[0] = i_ray.origin_x;
    assign w_o[1] = i_ray.origin_y;
    assign w_o[2] = i_ray.origin_z;
    assign w_d[0] = i_ray.dir_x;
    assign w_d[1] = i_ray.dir_y;
    assign w_d[2] = i_ray.dir_z;
    assign w_c[0] = i_cfg.center_x;
    assign w_c[1] = i_cfg.center_y;
    assign w_c[2] = i_cfg.center_z;

    // sign and magnitude of the direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1.o[i]   = w_o[i];
            n_s1.neg[i] = w_d[i][CW-1];
            n_s1.mag[i] = w_d[i][CW-1] ? CW'(~w_d[i] + 1'b1) : w_d[i];
        end
        n_s1.zero = 1'b0;
    end

    // squared length and zero direction flag
    always_comb begin
        n_len2      = r_sq[0] + r_sq[1] + r_sq[2];
        n_s3        = r_s2;
        n_s3.zero   = (n_len2 == '0);
    end

    // length root
    rsi_sqrt u_len (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_len2),
        .o_root (w_len)
    );

    // one divider lane per component
    for (genvar g = 0; g < 3; g++) begin : g_div
        rsi_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (rsi_pkg::NW'(r_sd[SL-1].mag[g]) << F),
            .i_den (w_len),
            .o_quo (w_q[g])
        );
    end

    // signed unit direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_sd[DL-1].neg[i]) begin
                n_u[i] = UW'(0) - UW'(w_q[i]);
            end else begin
                n_u[i] = UW'(w_q[i]);
            end
        end
    end

    // center offset per component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_co[i] = $signed({w_c[i][CW-1], w_c[i]}) - $signed({r_n1.o[i][CW-1], r_n1.o[i]});
        end
    end

    // projection, floor shift by the fraction
    always_comb begin
        w_psum       = r_pr[0] + r_pr[1] + r_pr[2];
        n_out.o      = r_n2.o;
        n_out.u      = r_u2;
        n_out.proj   = w_psum[PRW-1:F];
        n_out.miss   = r_n2.zero;
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_vp1 <= 1'b0;
            r_vp2 <= 1'b0;
            r_vp3 <= 1'b0;
            for (int k = 0; k < DL; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1    <= i_push;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vd[0] <= r_v3;
            for (int k = 1; k < DL; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_vp1 <= r_vd[DL-1];
            r_vp2 <= r_vp1;
            r_vp3 <= r_vp2;
        end
    end

    // payload line
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*CW)'(r_s1.mag[i]) * (2*CW)'(r_s1.mag[i]);
            end
            r_s3    <= n_s3;
            r_len2  <= n_len2;
            r_sd[0] <= r_s3;
            for (int k = 1; k < DL; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_n1 <= r_sd[DL-1];
            r_u  <= n_u;
            r_n2 <= r_n1;
            r_u2 <= r_u;
            for (int i = 0; i < 3; i++) begin
                r_pr[i] <= w_co[i] * $signed(r_u[i]);
            end
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[src/rsi_back.sv]
// back part: request queue, closest approach, chord root, root choice and hit point
// depends on rsi_pkg, rsi_sqrt
`default_nettype none

module rsi_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rsi_pkg::t_cfg   i_cfg,
    input  wire logic            i_push,
    input  wire rsi_pkg::t_norm  i_norm,
    output logic                 o_rdy,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output rsi_pkg::t_hit        o_hit
);

    localparam int F   = rsi_pkg::FRAC_BITS;
    localparam int CW  = rsi_pkg::CW;
    localparam int UW  = rsi_pkg::UW;
    localparam int PW  = rsi_pkg::PW;
    localparam int WW  = rsi_pkg::WW;
    localparam int TW  = rsi_pkg::TW;
    localparam int RDW = rsi_pkg::RAD_W;
    localparam int QD  = rsi_pkg::QD;
    localparam int QA  = rsi_pkg::QA;
    localparam int SL  = rsi_pkg::SQ_LAT;
    localparam int UPW = UW + PW;
    localparam int UTW = UW + TW;
    localparam int SW  = 2 * RDW;

    // ---------------- request queue from the front
    rsi_pkg::t_norm r_iq [QD];
    logic [QA-1:0]  r_iq_wr, r_iq_rd;
    logic [QA:0]    r_iq_cnt;
    logic           w_iq_empty, w_iq_pop;

    // ---------------- result queue
    rsi_pkg::t_hit  r_oq [QD];
    logic [QA-1:0]  r_oq_wr, r_oq_rd;
    logic [QA:0]    r_oq_cnt;
    logic           w_oq_full, w_oq_push, w_oq_pop;

    logic w_en;
    logic r_b1, r_b2, r_b3, r_b4, r_b5, r_b6, r_b7, r_b8;
    logic r_bd [SL];

    rsi_pkg::t_norm n_n1, r_n1, r_n2, n_n3, r_n3, r_n4, n_n5, r_n5, n_n6, r_n6, r_n7;
    rsi_pkg::t_norm r_nd [SL];
    rsi_pkg::t_hit  n_res, r_res;

    logic [2:0][CW-1:0]       w_c;
    logic [RDW-1:0]           w_lim;
    logic                     w_bad;
    logic signed [UPW-1:0]    r_up [3];
    logic signed [UPW-F-1:0]  w_sh [3];
    logic signed [UPW-F-1:0]  w_wx [3];
    logic [2:0][WW-1:0]       n_w, r_w;
    logic [WW-1:0]            w_mw [3];
    logic [RDW-1:0]           r_mw [3];
    logic [SW-1:0]            r_sq [3];
    logic [SW-1:0]            r_lim2, r_r2;
    logic [rsi_pkg::SQ_W-1:0] w_dist2, n_diff, r_diff;
    logic [rsi_pkg::SQ_R-1:0] w_delta;
    logic signed [TW-1:0]     w_t1, w_t2, w_ntol, n_t, r_t;
    logic signed [UTW-1:0]    r_tp [3];
    logic signed [UTW-F:0]    w_pt [3];
    logic [2:0][CW-1:0]       w_pnt;

    assign w_c[0] = i_cfg.center_x;
    assign w_c[1] = i_cfg.center_y;
    assign w_c[2] = i_cfg.center_z;

    // usable radius; no point lies strictly inside when radius is not above tolerance
    assign w_bad = i_cfg.radius <= RDW'(i_cfg.tolerance);
    assign w_lim = i_cfg.radius - RDW'(i_cfg.tolerance);

    // queue handshakes
    assign o_rdy      = (r_iq_cnt != (QA+1)'(QD));
    assign w_iq_empty = (r_iq_cnt == '0);
    assign w_oq_full  = (r_oq_cnt == (QA+1)'(QD));
    assign w_en       = !r_b8 || !w_oq_full;
    assign w_iq_pop   = w_en && !w_iq_empty;
    assign w_oq_push  = r_b8 && !w_oq_full;
    assign o_empty    = (r_oq_cnt == '0);
    assign w_oq_pop   = i_pop && !o_empty;
    assign o_hit      = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq_wr  <= '0;
            r_iq_rd  <= '0;
            r_iq_cnt <= '0;
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (i_push) begin
                r_iq_wr <= r_iq_wr + 1'b1;
            end
            if (w_iq_pop) begin
                r_iq_rd <= r_iq_rd + 1'b1;
            end
            r_iq_cnt <= r_iq_cnt + (QA+1)'(i_push) - (QA+1)'(w_iq_pop);
            if (w_oq_push) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + (QA+1)'(w_oq_push) - (QA+1)'(w_oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_iq[r_iq_wr] <= i_norm;
        end
        if (w_oq_push) begin
            r_oq[r_oq_wr] <= r_res;
        end
    end

    // stage one: head of queue, flag unusable radius
    always_comb begin
        n_n1      = r_iq[r_iq_rd];
        n_n1.miss = n_n1.miss | w_bad;
    end

    // stage two: closest approach offset from the center
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = r_up[i][UPW-1:F];
            w_wx[i] = w_sh[i] + (UPW-F)'($signed(r_n1.o[i])) - (UPW-F)'($signed(w_c[i]));
            n_w[i]  = w_wx[i][WW-1:0];
        end
    end

    // stage three: magnitudes, reject when any axis is already out
    always_comb begin
        n_n3 = r_n2;
        for (int i = 0; i < 3; i++) begin
            w_mw[i] = r_w[i][WW-1] ? (WW'(0) - r_w[i]) : r_w[i];
            if (w_mw[i] >= WW'(w_lim)) begin
                n_n3.miss = 1'b1;
            end
        end
    end

    // stage five: squared distance against the usable radius
    always_comb begin
        w_dist2 = rsi_pkg::SQ_W'(r_sq[0]) + rsi_pkg::SQ_W'(r_sq[1]) + rsi_pkg::SQ_W'(r_sq[2]);
        n_n5    = r_n4;
        if (w_dist2 >= rsi_pkg::SQ_W'(r_lim2)) begin
            n_n5.miss = 1'b1;
        end
        n_diff = rsi_pkg::SQ_W'(r_r2) - w_dist2;
    end

    // chord half-length
    rsi_sqrt u_chord (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_diff),
        .o_root (w_delta)
    );

    // pick the nearer root that is no more than the tolerance behind the origin
    always_comb begin
        n_n6   = r_nd[SL-1];
        w_t1   = TW'($signed(r_nd[SL-1].proj)) - $signed(TW'(w_delta));
        w_t2   = TW'($signed(r_nd[SL-1].proj)) + $signed(TW'(w_delta));
        w_ntol = TW'(0) - $signed(TW'(i_cfg.tolerance));
        if (w_t1 >= w_ntol) begin
            n_t = w_t1;
        end else if (w_t2 >= w_ntol) begin
            n_t = w_t2;
        end else begin
            n_t       = w_t1;
            n_n6.miss = 1'b1;
        end
    end

    // hit point, saturated to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pt[i] = (UTW-F+1)'($signed(r_tp[i][UTW-1:F])) + (UTW-F+1)'($signed(r_n7.o[i]));
            if (w_pt[i] > $signed((UTW-F+1)'({1'b0, {(CW-1){1'b1}}}))) begin
                w_pnt[i] = {1'b0, {(CW-1){1'b1}}};
            end else if (w_pt[i] < (UTW-F+1)'($signed({1'b1, {(CW-1){1'b0}}}))) begin
                w_pnt[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                w_pnt[i] = w_pt[i][CW-1:0];
            end
        end
        n_res.hit = !r_n7.miss;
        if (r_n7.miss) begin
            n_res.point_x = '0;
            n_res.point_y = '0;
            n_res.point_z = '0;
        end else begin
            n_res.point_x = w_pnt[0];
            n_res.point_y = w_pnt[1];
            n_res.point_z = w_pnt[2];
        end
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1 <= 1'b0;
            r_b2 <= 1'b0;
            r_b3 <= 1'b0;
            r_b4 <= 1'b0;
            r_b5 <= 1'b0;
            r_b6 <= 1'b0;
            r_b7 <= 1'b0;
            r_b8 <= 1'b0;
            for (int k = 0; k < SL; k++) begin
                r_bd[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_b1    <= !w_iq_empty;
            r_b2    <= r_b1;
            r_b3    <= r_b2;
            r_b4    <= r_b3;
            r_b5    <= r_b4;
            r_bd[0] <= r_b5;
            for (int k = 1; k < SL; k++) begin
                r_bd[k] <= r_bd[k-1];
            end
            r_b6 <= r_bd[SL-1];
            r_b7 <= r_b6;
            r_b8 <= r_b7;
        end
    end

    // payload line
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1 <= n_n1;
            for (int i = 0; i < 3; i++) begin
                r_up[i] <= $signed(n_n1.u[i]) * $signed(n_n1.proj);
            end
            r_n2 <= r_n1;
            r_w  <= n_w;
            r_n3 <= n_n3;
            for (int i = 0; i < 3; i++) begin
                r_mw[i] <= w_mw[i][RDW-1:0];
            end
            r_n4 <= r_n3;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SW'(r_mw[i]) * SW'(r_mw[i]);
            end
            r_lim2  <= SW'(w_lim) * SW'(w_lim);
            r_r2    <= SW'(i_cfg.radius) * SW'(i_cfg.radius);
            r_n5    <= n_n5;
            r_diff  <= n_diff;
            r_nd[0] <= r_n5;
            for (int k = 1; k < SL; k++) begin
                r_nd[k] <= r_nd[k-1];
            end
            r_n6 <= n_n6;
            r_t  <= n_t;
            r_n7 <= r_n6;
            for (int i = 0; i < 3; i++) begin
                r_tp[i] <= $signed(r_n6.u[i]) * r_t;
            end
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

[sim/rsi_checker.sv]
// checker for the ray and sphere intersection core: watches both queue ports,
// predicts each hit result from the sphere registers and compares in order
// depends on rsi_pkg
`timescale 1ns / 100ps

module rsi_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rsi_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [rsi_pkg::CW-1:0]    i_cfg_data,
    input  logic                      i_push,
    input  logic                      i_full,
    input  rsi_pkg::t_ray             i_ray,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  rsi_pkg::t_hit             i_hit,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_accepts
);
    import rsi_pkg::*;

    // shadow copy of the sphere registers
    logic signed [CW-1:0] sph_cx, sph_cy, sph_cz;
    logic [RAD_W-1:0]     sph_radius;
    logic [TOL_W-1:0]     sph_tol;

    t_hit expected_hits[$];
    int   n_errors;
    int   n_accepts;

    assign o_errors  = n_errors;
    assign o_pending = expected_hits.size();
    assign o_accepts = n_accepts;

    // floor shift by the fraction bits
    function automatic logic signed [127:0] floor_shift(input logic signed [127:0] x);
        floor_shift = x >>> FRAC_BITS;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] res, bitv, rem;
        res  = 0;
        rem  = x;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        int_root = res;
    endfunction

    function automatic logic signed [CW-1:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647)
            clamp32 = 32'sh7fffffff;
        else if (x < -128'sd2147483648)
            clamp32 = 32'sh80000000;
        else
            clamp32 = x[CW-1:0];
    endfunction

    // nearest intersection of one ray with the configured sphere
    function automatic t_hit predict_hit(input t_ray ray);
        logic signed [127:0] org[3], dv[3], ctr[3], unit[3], off[3];
        logic signed [127:0] proj, t1, t2, tsel, tol;
        logic [127:0] len2, dist2, lim, mg;
        logic [63:0]  len, delta, q;
        t_hit res;
        res = '0;
        predict_hit = res;
        org[0] = ray.origin_x; org[1] = ray.origin_y; org[2] = ray.origin_z;
        dv[0]  = ray.dir_x;    dv[1]  = ray.dir_y;    dv[2]  = ray.dir_z;
        ctr[0] = sph_cx;       ctr[1] = sph_cy;       ctr[2] = sph_cz;
        tol    = {112'd0, sph_tol};
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += dv[i] * dv[i];
        if (len2 == 0) return res;
        len = int_root(len2[63:0]);
        for (int i = 0; i < 3; i++) begin
            mg = dv[i] < 0 ? -dv[i] : dv[i];
            q  = (mg << FRAC_BITS) / len;
            unit[i] = dv[i] < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q});
        end
        proj = 0;
        for (int i = 0; i < 3; i++) proj += (ctr[i] - org[i]) * unit[i];
        proj = floor_shift(proj);
        if (sph_radius <= sph_tol) return res;
        lim   = sph_radius - sph_tol;
        dist2 = 0;
        for (int i = 0; i < 3; i++) begin
            off[i] = org[i] + floor_shift(unit[i] * proj) - ctr[i];
            mg = off[i] < 0 ? -off[i] : off[i];
            if (mg >= lim) return res;
            dist2 += mg * mg;
        end
        if (dist2 >= lim * lim) return res;
        delta = int_root(sph_radius * sph_radius - dist2[63:0]);
        t1 = proj - $signed({64'd0, delta});
        t2 = proj + $signed({64'd0, delta});
        if (t1 >= -tol)      tsel = t1;
        else if (t2 >= -tol) tsel = t2;
        else return res;
        res.hit     = 1'b1;
        res.point_x = clamp32(org[0] + floor_shift(unit[0] * tsel));
        res.point_y = clamp32(org[1] + floor_shift(unit[1] * tsel));
        res.point_z = clamp32(org[2] + floor_shift(unit[2] * tsel));
        predict_hit = res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // register writes, requests in and results out
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            sph_cx     <= '0;
            sph_cy     <= '0;
            sph_cz     <= '0;
            sph_radius <= RAD_W'(65536);
            sph_tol    <= TOL_W'(1);
            expected_hits.delete();
            n_errors  <= 0;
            n_accepts <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_CENTER_X:  sph_cx     <= i_cfg_data;
                    REG_CENTER_Y:  sph_cy     <= i_cfg_data;
                    REG_CENTER_Z:  sph_cz     <= i_cfg_data;
                    REG_RADIUS:    sph_radius <= i_cfg_data[RAD_W-1:0];
                    REG_TOLERANCE: sph_tol    <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            n_accepts <= n_accepts + int'(i_push && !i_full) + int'(i_pop && !i_empty);
            if (i_push && !i_full) begin
                expected_hits.push_back(predict_hit(i_ray));
            end
            if (i_pop && !i_empty) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_hit), 64'd0);
                end else begin
                    want = expected_hits.pop_front();
                    if (i_hit.hit !== want.hit)
                        report_mismatch("hit", 64'(i_hit.hit), 64'(want.hit));
                    if (i_hit.point_x !== want.point_x)
                        report_mismatch("point_x", 64'(i_hit.point_x), 64'(want.point_x));
                    if (i_hit.point_y !== want.point_y)
                        report_mismatch("point_y", 64'(i_hit.point_y), 64'(want.point_y));
                    if (i_hit.point_z !== want.point_z)
                        report_mismatch("point_z", 64'(i_hit.point_z), 64'(want.point_z));
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
// top of the ray and sphere intersection testbench: clock, reset, stimulus, verdict
// depends on rsi_pkg, ray_sphere_intersect_core and rsi_checker
`timescale 1ns / 100ps

module testbench;
    import rsi_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = '0;
    logic [CW-1:0] cfg_data = '0;
    logic          push = 1'b0;
    logic          full;
    t_ray          ray = '0;
    logic          empty;
    logic          pop = 1'b0;
    t_hit          hit_out;
    int            n_errors, n_pending, n_accepts;
    int            send_idle = 0, recv_idle = 0;
    int            hold_off = 0;
    int            idle_cycles = 0;
    int            last_accepts = 0;

    always #4 i_clk = ~i_clk;

    ray_sphere_intersect_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .push(push), .full(full), .i_ray(ray),
        .empty(empty), .pop(pop), .o_hit(hit_out)
    );

    rsi_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_push(push), .i_full(full), .i_ray(ray),
        .i_empty(empty), .i_pop(pop), .i_hit(hit_out),
        .o_errors(n_errors), .o_pending(n_pending), .o_accepts(n_accepts)
    );

    // receiver: random pops, with an optional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end else
            pop <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        if (n_accepts != last_accepts) begin
            last_accepts <= n_accepts;
            idle_cycles  <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CW-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [CW-1:0] cz, input logic [CW-1:0] rad,
                              input logic [CW-1:0] tol);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_TOLERANCE, tol);
    endtask

    // offer one request until accepted; push stays high across back-to-back requests
    task automatic send_ray(input t_ray r);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        ray  <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for all results, then let the pipeline drain
    task automatic drain;
        push <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(input int scale);
        case (scale)
            0: rand_coord = $urandom;
            1: rand_coord = 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            default: rand_coord = 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        endcase
    endfunction

    // rays aimed mostly near the sphere so that hits and both roots show up
    function automatic t_ray aimed_ray(input logic signed [CW-1:0] cx,
                                       input logic signed [CW-1:0] cy,
                                       input logic signed [CW-1:0] cz, input int scale);
        t_ray r;
        r.origin_x = rand_coord(scale);
        r.origin_y = rand_coord(scale);
        r.origin_z = rand_coord(scale);
        if ($urandom_range(3) != 0) begin
            r.dir_x = cx - r.origin_x + $signed(rand_coord(1)) / 4;
            r.dir_y = cy - r.origin_y + $signed(rand_coord(1)) / 4;
            r.dir_z = cz - r.origin_z + $signed(rand_coord(1)) / 4;
            if ($urandom_range(3) == 0) begin
                r.dir_x = -r.dir_x; r.dir_y = -r.dir_y; r.dir_z = -r.dir_z;
            end
        end else begin
            r.dir_x = rand_coord(scale);
            r.dir_y = rand_coord(scale);
            r.dir_z = rand_coord(scale);
        end
        aimed_ray = r;
    endfunction

    t_ray r;

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset sphere, axis rays, inside, behind, zero direction, extremes
        r = '0; r.origin_x = -32'sd196608; r.dir_x = 32'sd65536;      send_ray(r);
        r = '0; r.origin_x = 32'sd196608;  r.dir_x = 32'sd65536;      send_ray(r);
        r = '0; r.dir_y = -32'sd3;                                    send_ray(r);
        r = '0; r.origin_z = -32'sd131072;                            send_ray(r);
        r = '0; r.origin_y = 32'sd65536; r.origin_z = -32'sd200000;
        r.dir_z = 32'sd1000;                                          send_ray(r);
        r = '1;                                                       send_ray(r);
        r = {6{32'h7fffffff}};                                        send_ray(r);
        r = {6{32'h80000000}};                                        send_ray(r);
        r = '0; r.dir_x = 32'sh80000000; r.dir_y = 32'sh7fffffff;     send_ray(r);
        drain();

        // directed: radius equal to tolerance, then zero radius
        set_sphere(32'sd0, 32'sd0, 32'sd0, 32'd100, 32'd100);
        r = '0; r.origin_x = -32'sd65536; r.dir_x = 32'sd1;           send_ray(r);
        drain();
        set_sphere(32'sh7fffffff, 32'sh80000000, 32'sd0, 32'd0, 32'd0);
        r = '0; r.dir_x = 32'sd1;                                     send_ray(r);
        drain();
        // huge sphere, saturating points
        set_sphere(32'sh7fff0000, 32'sh80010000, 32'sh7fff0000, 32'h7fffffff, 32'hffff);
        r = '0; r.dir_x = 32'sd1; r.dir_y = -32'sd1; r.dir_z = 32'sd1; send_ray(r);
        r = '0; r.origin_x = 32'sh80000000; r.dir_x = -32'sd5;        send_ray(r);
        r = {6{32'h80000000}};                                        send_ray(r);
        drain();

        // long receiver hold-off while requests keep coming, enough to fill the block
        set_sphere(32'sd0, 32'sd0, 32'sd0, 32'd200000, 32'd1);
        hold_off = 300;
        for (int i = 0; i < 150; i++) send_ray(aimed_ray(0, 0, 0, 1));
        drain();

        // random phases: three idle mixes, several sphere settings each
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 32 : (ph == 1) ? 82 : 0;
            recv_idle = (ph == 0) ? 82 : (ph == 1) ? 32 : 0;
            for (int s = 0; s < 4; s++) begin
                logic signed [CW-1:0] cx, cy, cz;
                int scale;
                scale = (s == 3) ? 0 : (s % 2) + 1;
                cx = rand_coord(scale == 0 ? 2 : scale);
                cy = rand_coord(scale == 0 ? 2 : scale);
                cz = rand_coord(scale == 0 ? 2 : scale);
                set_sphere(cx, cy, cz,
                           (s == 3) ? $urandom_range(0, 32'h7fffffff)
                                    : $urandom_range(1000, 32'h0020_0000),
                           (s == 2) ? $urandom_range(0, 16'hffff) : $urandom_range(0, 64));
                for (int i = 0; i < 30; i++) send_ray(aimed_ray(cx, cy, cz, scale));
                drain();
            end
        end

        if (n_errors == 0 && n_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
